/* hdl/lbpz_pkg.sv */
// Shared types, constants and the pattern function for the 3x3 LBP block.
`default_nettype none

package lbpz_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int NEIGHBOURS    = 8;
  localparam int WIDTH_RST     = 640;
  localparam int HEIGHT_RST    = 480;
  localparam int IMG_W_BITS    = 11;
  localparam int IMG_H_BITS    = 16;
  localparam int CFG_W         = 16;

  // result queue: power-of-two depth
  localparam int OF_DEPTH = 8;
  localparam int OF_AW    = $clog2(OF_DEPTH);
  localparam int OF_CW    = OF_AW + 1;

  typedef logic [7:0]            pix_t;
  typedef logic [NEIGHBOURS-1:0] code_t;
  typedef logic [IMG_H_BITS-1:0] row_t;
  typedef pix_t [2:0]            col_t;   // indexed by window row
  typedef col_t [2:0]            win_t;   // indexed by window column

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // stage-1 control word handed from the sequencer to the datapath
  typedef struct packed {
    logic vld;
    logic is_pix;
    logic emit_a;
    logic emit_b;
    logic top;
    logic left;
    logic last;
    pix_t px;
  } s1_ctl_t;

  typedef struct packed {
    code_t code;
    logic  eor;
    logic  eoi;
    logic  lor;
  } res_t;

  // centre at column 1, row 1; neighbours clockwise from top-left
  function automatic code_t lbp_code(input win_t w, input logic top, input logic bot,
                                     input logic lft, input logic rgt);
    pix_t  ctr;
    code_t code;
    ctr     = w[1][1];
    code[0] = top & lft & (w[0][0] >= ctr);
    code[1] = top & (w[1][0] >= ctr);
    code[2] = top & rgt & (w[2][0] >= ctr);
    code[3] = rgt & (w[2][1] >= ctr);
    code[4] = bot & rgt & (w[2][2] >= ctr);
    code[5] = bot & (w[1][2] >= ctr);
    code[6] = bot & lft & (w[0][2] >= ctr);
    code[7] = lft & (w[0][1] >= ctr);
    return code;
  endfunction

endpackage

`default_nettype wire

/* hdl/lbpz_if.sv */
// Valid/ready channel interfaces for pixel words and result words.
`default_nettype none

interface lbpz_in_if import lbpz_pkg::*; ();
  logic valid;
  logic ready;
  logic op;
  pix_t pixel_value;

  modport source (output valid, output op, output pixel_value, input ready);
  modport sink   (input valid, input op, input pixel_value, output ready);
endinterface

interface lbpz_out_if import lbpz_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t lbp_code;
  logic  end_of_row;
  logic  end_of_image;
  logic  last_of_run;

  modport source (output valid, output lbp_code, output end_of_row, output end_of_image,
                  output last_of_run, input ready);
  modport sink   (input valid, input lbp_code, input end_of_row, input end_of_image,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

/* hdl/lbpz_ram.sv */
// Generic synchronous RAM: one write port, two registered read ports.
`default_nettype none

module lbpz_ram import lbpz_pkg::*; #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = MAX_WIDTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a_r,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

endmodule

`default_nettype wire

/* hdl/lbpz_ctrl.sv */
// Sequencer: configuration, raster counters, line buffer addressing, stage-1 control.
`default_nettype none

module lbpz_ctrl import lbpz_pkg::*; #(
  parameter  int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int AW        = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  pix_t             in_px,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic [OF_CW-1:0] of_level,
  output logic [AW-1:0]    raddr_a,
  output logic [AW-1:0]    raddr_b,
  output s1_ctl_t          s1_ctl_r,
  output logic [AW-1:0]    s1_addr_r
);

  localparam int RST_W = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
  localparam int RW    = OF_CW + 1;

  logic [AW-1:0]         col_last_r, col_last_nxt;
  logic [AW-1:0]         col_r, col_nxt;
  logic [AW-1:0]         flush_r, flush_nxt;
  row_t                  h_eff_r, h_eff_nxt;
  row_t                  row_r, row_nxt;
  logic [IMG_W_BITS-1:0] wv;
  row_t                  hv;
  logic                  drain, accept, is_pix, row_end, fl_last;
  logic [AW-1:0]         c;
  row_t                  r;
  s1_ctl_t               s1_nxt;
  logic [AW-1:0]         s1_addr_nxt;
  logic [RW-1:0]         reserve;

  // keep room for two results per word still in flight
  assign reserve  = {1'b0, of_level} + (s1_ctl_r.vld ? RW'(2) : RW'(0));
  assign in_ready = reserve <= RW'(OF_DEPTH - 2);

  always_comb begin
    drain   = row_r >= h_eff_r;
    accept  = in_valid & in_ready;
    is_pix  = in_op == OP_PIXEL;
    c       = drain ? '0 : col_r;
    r       = drain ? '0 : row_r;
    row_end = c == col_last_r;
    fl_last = flush_r == col_last_r;
    raddr_a = is_pix ? c : flush_r;
    raddr_b = fl_last ? flush_r : flush_r + AW'(1);
    wv      = cfg_wdata[IMG_W_BITS-1:0];
    hv      = cfg_wdata[IMG_H_BITS-1:0];

    col_nxt      = col_r;
    row_nxt      = row_r;
    flush_nxt    = flush_r;
    col_last_nxt = col_last_r;
    h_eff_nxt    = h_eff_r;
    s1_nxt       = '0;
    s1_nxt.px    = in_px;
    s1_addr_nxt  = s1_addr_r;

    if (accept) begin
      if (is_pix) begin
        // a pixel in drain restarts the image at top-left
        s1_nxt.vld    = 1'b1;
        s1_nxt.is_pix = 1'b1;
        s1_nxt.emit_a = (r != '0) && (c != '0);
        s1_nxt.emit_b = (r != '0) && row_end;
        s1_nxt.top    = r > row_t'(1);
        s1_nxt.left   = c > AW'(1);
        s1_addr_nxt   = c;
        if (row_end) begin
          col_nxt   = '0;
          row_nxt   = r + row_t'(1);
          flush_nxt = '0;
        end else begin
          col_nxt = c + AW'(1);
          row_nxt = r;
          if (drain) begin
            flush_nxt = '0;
          end
        end
      end else if (drain) begin
        s1_nxt.vld    = 1'b1;
        s1_nxt.emit_a = 1'b1;
        s1_nxt.top    = 1'b1;
        s1_nxt.left   = flush_r != '0;
        s1_nxt.last   = fl_last;
        s1_addr_nxt   = flush_r;
        if (fl_last) begin
          col_nxt   = '0;
          row_nxt   = '0;
          flush_nxt = '0;
        end else begin
          flush_nxt = flush_r + AW'(1);
        end
      end
    end

    if (cfg_we) begin
      col_nxt   = '0;
      row_nxt   = '0;
      flush_nxt = '0;
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (int'(wv) > MAX_WIDTH) begin
            col_last_nxt = AW'(MAX_WIDTH - 1);
          end else if (wv < IMG_W_BITS'(2)) begin
            col_last_nxt = AW'(1);
          end else begin
            col_last_nxt = AW'(wv - IMG_W_BITS'(1));
          end
        end
        REG_IMAGE_HEIGHT: begin
          h_eff_nxt = (hv < row_t'(2)) ? row_t'(2) : hv;
        end
        default: begin
          h_eff_nxt = h_eff_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= AW'(RST_W - 1);
      h_eff_r    <= row_t'(HEIGHT_RST);
      col_r      <= '0;
      row_r      <= '0;
      flush_r    <= '0;
      s1_ctl_r   <= '0;
    end else begin
      col_last_r <= col_last_nxt;
      h_eff_r    <= h_eff_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      flush_r    <= flush_nxt;
      s1_ctl_r   <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= s1_addr_nxt;
  end

endmodule

`default_nettype wire

/* hdl/lbpz_dp.sv */
// Stage 1: read forwarding, line buffer write-back, 3x3 window and pattern codes.
`default_nettype none

module lbpz_dp import lbpz_pkg::*; #(
  parameter  int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int AW        = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  s1_ctl_t       s1_ctl,
  input  logic [AW-1:0] s1_addr,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  input  pix_t          ab_rd_a,
  input  pix_t          ab_rd_b,
  input  pix_t          tw_rd_a,
  input  pix_t          tw_rd_b,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output pix_t          ab_wdata,
  output pix_t          tw_wdata,
  output logic          push_a,
  output logic          push_b,
  output res_t          res_a,
  output res_t          res_b
);

  win_t win_r, win_nxt, win_end;
  logic hit_a_r, hit_b_r;
  pix_t fwd_ab_r, fwd_tw_r;
  pix_t above_c, two_c, above_hi, two_hi;

  always_comb begin
    // both buffers share the write address, so one hit flag per read port
    above_c  = hit_a_r ? fwd_ab_r : ab_rd_a;
    two_c    = hit_a_r ? fwd_tw_r : tw_rd_a;
    above_hi = hit_b_r ? fwd_ab_r : ab_rd_b;
    two_hi   = hit_b_r ? fwd_tw_r : tw_rd_b;

    // rows shift up through the two line buffers
    wr_en    = s1_ctl.vld & s1_ctl.is_pix;
    wr_addr  = s1_addr;
    ab_wdata = s1_ctl.px;
    tw_wdata = above_c;

    win_nxt[0] = win_r[1];
    if (s1_ctl.is_pix) begin
      win_nxt[1] = win_r[2];
      win_nxt[2] = {s1_ctl.px, above_c, two_c};
    end else begin
      // drain: last row is centre, bottom row unused
      win_nxt[1] = {pix_t'(0), above_c, two_c};
      win_nxt[2] = {pix_t'(0), above_hi, two_hi};
    end

    // end-of-row result: centre one column further right, no right side
    win_end[0] = win_nxt[1];
    win_end[1] = win_nxt[2];
    win_end[2] = '0;

    res_a.code = lbp_code(win_nxt, s1_ctl.top, s1_ctl.is_pix, s1_ctl.left,
                          s1_ctl.is_pix | ~s1_ctl.last);
    res_a.eor  = ~s1_ctl.is_pix & s1_ctl.last;
    res_a.eoi  = ~s1_ctl.is_pix & s1_ctl.last;
    res_a.lor  = ~s1_ctl.emit_b;

    res_b.code = lbp_code(win_end, s1_ctl.top, 1'b1, 1'b1, 1'b0);
    res_b.eor  = 1'b1;
    res_b.eoi  = 1'b0;
    res_b.lor  = 1'b1;

    push_a = s1_ctl.vld & s1_ctl.emit_a;
    push_b = s1_ctl.vld & s1_ctl.emit_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      hit_a_r <= 1'b0;
      hit_b_r <= 1'b0;
    end else begin
      if (s1_ctl.vld) begin
        win_r <= win_nxt;
      end
      hit_a_r <= wr_en && (wr_addr == raddr_a);
      hit_b_r <= wr_en && (wr_addr == raddr_b);
    end
  end

  always_ff @(posedge clk) begin
    fwd_ab_r <= ab_wdata;
    fwd_tw_r <= tw_wdata;
  end

endmodule

`default_nettype wire

/* hdl/lbpz_ofifo.sv */
// Result queue: takes up to two result words a cycle, gives one while out_ready is high.
`default_nettype none

module lbpz_ofifo import lbpz_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_a,
  input  res_t             res_a,
  input  logic             push_b,
  input  res_t             res_b,
  output logic [OF_CW-1:0] level,
  output logic             out_valid,
  input  logic             out_ready,
  output res_t             out_res
);

  res_t             mem_r [OF_DEPTH];
  logic [OF_AW-1:0] wptr_r, rptr_r, wptr_b;
  logic [OF_CW-1:0] cnt_r;
  logic             pop;

  assign out_valid = cnt_r != '0;
  assign out_res   = mem_r[rptr_r];
  assign level     = cnt_r;
  assign pop       = out_valid & out_ready;
  assign wptr_b    = push_a ? wptr_r + OF_AW'(1) : wptr_r;

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[wptr_r] <= res_a;
    end
    if (push_b) begin
      mem_r[wptr_b] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + OF_AW'(push_a) + OF_AW'(push_b);
      rptr_r <= rptr_r + OF_AW'(pop);
      cnt_r  <= cnt_r + OF_CW'(push_a) + OF_CW'(push_b) - OF_CW'(pop);
    end
  end

endmodule

`default_nettype wire

/* hdl/lbp_3x3_edge_zero_top.sv */
// Top level of the 3x3 edge-zero local binary pattern block.
//
//   port      dir   handshake       word
//   in_ch     in    valid/ready     op, pixel_value
//   out_ch    out   valid/ready     lbp_code, end_of_row, end_of_image, last_of_run
//   cfg_*     in    cfg_we only     cfg_index, cfg_wdata (no read-back)
//
// One input word a clock while in_ch.ready is high, pixel or flush. The accepting
// edge also registers the line buffer reads; the next cycle is the window/compare
// stage, whose results are registered into the output queue. in_ch.ready drops
// only when the 8-entry result queue cannot hold two more results per word in
// flight.
// Synchronous active-low reset clears counters, window and queue; width 640,
// height 480. Line buffers are not cleared; their stale rows are masked.
`default_nettype none

module lbp_3x3_edge_zero_top import lbpz_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  lbpz_in_if.sink          in_ch,
  lbpz_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);

  // line buffer addressing and stage-1 control
  logic [AW-1:0]    raddr_a, raddr_b;
  s1_ctl_t          s1_ctl;
  logic [AW-1:0]    s1_addr;

  // line buffer data: row above (ab) and row two above (tw)
  pix_t             ab_rd_a, ab_rd_b, tw_rd_a, tw_rd_b;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  pix_t             ab_wdata, tw_wdata;

  // results into the queue
  logic             push_a, push_b;
  res_t             res_a, res_b, out_res;
  logic [OF_CW-1:0] of_level;

  lbpz_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .in_px     (in_ch.pixel_value),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .of_level  (of_level),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .s1_ctl_r  (s1_ctl),
    .s1_addr_r (s1_addr)
  );

  // port a: current column (pixel) or drain column; port b: drain right neighbour
  lbpz_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_ram_above (
    .clk       (clk),
    .we        (wr_en),
    .waddr     (wr_addr),
    .wdata     (ab_wdata),
    .raddr_a   (raddr_a),
    .rdata_a_r (ab_rd_a),
    .raddr_b   (raddr_b),
    .rdata_b_r (ab_rd_b)
  );

  lbpz_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_ram_two (
    .clk       (clk),
    .we        (wr_en),
    .waddr     (wr_addr),
    .wdata     (tw_wdata),
    .raddr_a   (raddr_a),
    .rdata_a_r (tw_rd_a),
    .raddr_b   (raddr_b),
    .rdata_b_r (tw_rd_b)
  );

  // window, same-address forwarding and both pattern codes
  lbpz_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_ctl   (s1_ctl),
    .s1_addr  (s1_addr),
    .raddr_a  (raddr_a),
    .raddr_b  (raddr_b),
    .ab_rd_a  (ab_rd_a),
    .ab_rd_b  (ab_rd_b),
    .tw_rd_a  (tw_rd_a),
    .tw_rd_b  (tw_rd_b),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .ab_wdata (ab_wdata),
    .tw_wdata (tw_wdata),
    .push_a   (push_a),
    .push_b   (push_b),
    .res_a    (res_a),
    .res_b    (res_b)
  );

  lbpz_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (push_a),
    .res_a     (res_a),
    .push_b    (push_b),
    .res_b     (res_b),
    .level     (of_level),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.lbp_code     = out_res.code;
  assign out_ch.end_of_row   = out_res.eor;
  assign out_ch.end_of_image = out_res.eoi;
  assign out_ch.last_of_run  = out_res.lor;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for lbp_3x3_edge_zero_top: pixel and flush words checked against a behavioural model.
module tb_top;
  import lbpz_pkg::*;

  // ---------------------------------------------------------------------------
  // Bench constants
  // ---------------------------------------------------------------------------
  localparam int LINE_MAX       = MAX_WIDTH_DEF;
  localparam int RANDOM_WORDS   = 450;   // pixel and effective flush words in the random part
  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off for the back-pressure test
  localparam int SETTLE_CYCLES  = 4;     // two-stage pipe plus margin, before a register write
  localparam int TAIL_CYCLES    = 12;    // quiet time at the end to catch stray results
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake before giving up

  // 3x3 neighbourhood, [row][col], centre at [1][1]
  typedef logic [0:2][0:2][7:0] tile_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, configuration port and channels
  // ---------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  lbpz_in_if  pix_ch ();
  lbpz_out_if code_ch ();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  lbp_3x3_edge_zero_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_ch),
    .out_ch    (code_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Behavioural model state: two line stores, the sliding window, the raster
  // position and the drain position, plus the two geometry registers.
  // ---------------------------------------------------------------------------
  pix_t                  line_above  [LINE_MAX];
  pix_t                  line_two_up [LINE_MAX];
  tile_t                 win_q;
  int unsigned           col_pos;
  int unsigned           row_pos;
  int unsigned           drain_pos;
  logic [IMG_W_BITS-1:0] width_reg;
  logic [IMG_H_BITS-1:0] height_reg;

  // Codes still owed by the block, oldest first
  res_t expected_codes [$];

  // Run bookkeeping
  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;
  int unsigned words_sent      = 0;
  int unsigned images_drained  = 0;
  int unsigned cfg_writes      = 0;
  int unsigned stall_cycles    = 0;
  int unsigned quiet_cycles    = 0;

  // Sender pacing
  bit          gaps_on    = 1'b1;
  int unsigned burst_left = 0;

  // Receiver pacing; the hold request is raised by a test and taken by the sink
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;
  logic [7:0]  ready_mask   = 8'hFF;
  logic [2:0]  ready_phase  = '0;
  int unsigned pattern_age  = 0;

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------
  function automatic int unsigned active_width();
    if (width_reg < 2) return 2;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg < 2) ? 2 : height_reg;
  endfunction

  function automatic void model_reset();
    int i;
    for (i = 0; i < LINE_MAX; i++) begin
      line_above[i]  = '0;
      line_two_up[i] = '0;
    end
    win_q      = '0;
    col_pos    = 0;
    row_pos    = 0;
    drain_pos  = 0;
    width_reg  = IMG_W_BITS'(WIDTH_RST);
    height_reg = IMG_H_BITS'(HEIGHT_RST);
  endfunction

  // A write restarts the image; the line stores keep their contents
  function automatic void geometry_write(reg_idx_t idx, logic [CFG_W-1:0] value);
    if (idx == REG_IMAGE_WIDTH) width_reg = value[IMG_W_BITS-1:0];
    else                        height_reg = value[IMG_H_BITS-1:0];
    col_pos   = 0;
    row_pos   = 0;
    drain_pos = 0;
  endfunction

  // Bit k set when neighbour k >= centre; missing sides give 0 bits.
  // Neighbours run clockwise from top-left (bit 0) to left (bit 7).
  function automatic code_t neighbour_code(tile_t t, logic top, logic bot, logic lft,
                                           logic rgt);
    code_t code;
    int    k, dr, dc;
    code = '0;
    for (k = 0; k < NEIGHBOURS; k++) begin
      case (k)
        0:       begin dr = -1; dc = -1; end
        1:       begin dr = -1; dc =  0; end
        2:       begin dr = -1; dc =  1; end
        3:       begin dr =  0; dc =  1; end
        4:       begin dr =  1; dc =  1; end
        5:       begin dr =  1; dc =  0; end
        6:       begin dr =  1; dc = -1; end
        default: begin dr =  0; dc = -1; end
      endcase
      if ((dr < 0 && !top) || (dr > 0 && !bot) || (dc < 0 && !lft) || (dc > 0 && !rgt))
        continue;
      if (t[1 + dr][1 + dc] >= t[1][1]) code[k] = 1'b1;
    end
    return code;
  endfunction

  function automatic res_t make_res(code_t code, logic eor, logic eoi);
    res_t r;
    r.code = code;
    r.eor  = eor;
    r.eoi  = eoi;
    r.lor  = 1'b0;
    return r;
  endfunction

  // Advance the model by one accepted word and queue the codes it releases.
  // Returns how many codes the word released (0, 1 or 2).
  function automatic int lbp_predict(op_t op, pix_t px);
    int unsigned w, h, c, r, k, lo, hi;
    int          i, j, n;
    pix_t        a, b;
    tile_t       t;
    logic        at_end;
    res_t        outs [2];
    w = active_width();
    h = active_height();
    n = 0;
    if (col_pos >= w) col_pos = 0;
    if (op == OP_PIXEL) begin
      // a pixel after the last row starts a fresh image, dropping any drain
      if (row_pos >= h) begin
        row_pos   = 0;
        col_pos   = 0;
        drain_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      a = line_above[c];
      b = line_two_up[c];
      line_two_up[c] = a;
      line_above[c]  = px;
      for (i = 0; i < 3; i++) begin
        win_q[i][0] = win_q[i][1];
        win_q[i][1] = win_q[i][2];
      end
      win_q[0][2] = b;
      win_q[1][2] = a;
      win_q[2][2] = px;
      // centre is the pixel one row up and one column left
      if (r >= 1 && c >= 1) begin
        outs[n] = make_res(neighbour_code(win_q, r > 1, 1'b1, c > 1, 1'b1), 1'b0, 1'b0);
        n++;
      end
      // last column of the row above, no right-hand neighbours
      if (r >= 1 && c == w - 1) begin
        for (i = 0; i < 3; i++)
          for (j = 0; j < 3; j++)
            t[i][j] = (j < 2) ? win_q[i][j + 1] : 8'd0;
        outs[n] = make_res(neighbour_code(t, r > 1, 1'b1, 1'b1, 1'b0), 1'b1, 1'b0);
        n++;
      end
      c++;
      if (c >= w) begin
        c         = 0;
        row_pos   = r + 1;
        drain_pos = 0;
      end
      col_pos = c;
    end else if (row_pos >= h && drain_pos < w) begin
      // drain one pixel of the bottom row, nothing below it
      k      = drain_pos;
      lo     = (k > 0) ? k - 1 : 0;
      hi     = (k + 1 < w) ? k + 1 : k;
      at_end = (k == w - 1);
      t       = '0;
      t[0][0] = line_two_up[lo];
      t[0][1] = line_two_up[k];
      t[0][2] = line_two_up[hi];
      t[1][0] = line_above[lo];
      t[1][1] = line_above[k];
      t[1][2] = line_above[hi];
      outs[n] = make_res(neighbour_code(t, 1'b1, 1'b0, k > 0, !at_end), at_end, at_end);
      n++;
      drain_pos = k + 1;
      if (at_end) begin
        row_pos   = 0;
        col_pos   = 0;
        drain_pos = 0;
        images_drained++;
      end
    end
    if (n > 0) outs[n - 1].lor = 1'b1;
    for (i = 0; i < n; i++) expected_codes.push_back(outs[i]);
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string what);
    mismatch_count++;
    $display("%0t mismatch %0d: %s", $time, mismatch_count, what);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result word against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : code_check
    res_t want;
    if (rst_n === 1'b1 && code_ch.valid === 1'b1 && code_ch.ready === 1'b1) begin
      results_checked++;
      if (expected_codes.size() == 0) begin
        flag_mismatch($sformatf("code %02h eor %0b eoi %0b lor %0b with nothing expected",
                                code_ch.lbp_code, code_ch.end_of_row, code_ch.end_of_image,
                                code_ch.last_of_run));
      end else begin
        want = expected_codes.pop_front();
        if (code_ch.lbp_code !== want.code || code_ch.end_of_row !== want.eor ||
            code_ch.end_of_image !== want.eoi || code_ch.last_of_run !== want.lor) begin
          flag_mismatch($sformatf(
            "result %0d got/want: code %02h/%02h eor %0b/%0b eoi %0b/%0b lor %0b/%0b",
            results_checked, code_ch.lbp_code, want.code, code_ch.end_of_row, want.eor,
            code_ch.end_of_image, want.eoi, code_ch.last_of_run, want.lor));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver pacing. Normally a random ready pattern from an 8-bit mask, reloaded
  // when pattern_age runs out (a quarter of the time all-ready). A hold request
  // from a test drops ready, counted down here from HOLD_CYCLES.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : sink_pace
    logic nxt;
    if (rst_n !== 1'b1) begin
      nxt = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      nxt = 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      nxt          = 1'b0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age = 48;
        ready_mask  = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      pattern_age--;
      nxt = ready_mask[ready_phase];
      ready_phase++;
    end
    code_ch.ready <= nxt;
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no handshake of any kind for too long ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b0) stall_cycles++;
    if (rst_n !== 1'b1 || (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
        (code_ch.valid === 1'b1 && code_ch.ready === 1'b1) || cfg_we === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no traffic for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_codes.size());
        $display("[lbp_3x3_edge_zero_top] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one word from the falling edge and hold it until taken. Valid stays
  // high on return so that the next word follows back to back.
  task automatic send_word(op_t op, pix_t px);
    int n;
    @(negedge clk);
    pix_ch.valid       <= 1'b1;
    pix_ch.op          <= op;
    pix_ch.pixel_value <= px;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    n = lbp_predict(op, px);
    // flushes with nothing to drain are ignored by the block
    if (op == OP_PIXEL || n > 0) words_sent++;
  endtask

  // Idle the sender with valid low, payload scrambled meanwhile
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      pix_ch.valid       <= 1'b0;
      pix_ch.op          <= 1'($urandom);
      pix_ch.pixel_value <= 8'($urandom);
    end
  endtask

  // Send in bursts of random length, with random gaps between them when gaps_on is set
  task automatic push_word(op_t op, pix_t px);
    if (burst_left == 0) begin
      if (gaps_on) idle_cycles($urandom_range(1, 5));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    send_word(op, px);
  endtask

  task automatic park_sender();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
  endtask

  task automatic wait_results_in();
    while (expected_codes.size() != 0) @(posedge clk);
  endtask

  // Register writes only with the block idle: all codes back, then a short
  // settle for words that released nothing but may still be in the pipe.
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
    park_sender();
    wait_results_in();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    geometry_write(idx, value);
    cfg_writes++;
  endtask

  function automatic pix_t random_pixel(int unsigned mode, pix_t base);
    case (mode)
      0:       return pix_t'($urandom);
      1:       return base + pix_t'($urandom_range(0, 3));   // near-equal levels
      2:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default: return ($urandom_range(0, 7) == 0) ? pix_t'($urandom) : base;  // flat areas
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Geometry straight out of reset: 640 wide, so only the second row releases
  // codes. Stops part way into row 1 to keep the run short.
  task automatic test_reset_geometry();
    repeat (WIDTH_RST + 10) push_word(OP_PIXEL, pix_t'($urandom));
  endtask

  // Short hand-picked sequence: clamped geometry, extreme levels, flush with
  // nothing to drain, flush mid-image, a pixel abandoning a drain.
  task automatic test_directed_cases();
    write_reg(REG_IMAGE_WIDTH, 16'd0);     // clamps up to 2
    write_reg(REG_IMAGE_HEIGHT, 16'd1);    // counts as 2
    send_word(OP_PIXEL, 8'd0);             // first row: no codes
    send_word(OP_PIXEL, 8'd255);
    send_word(OP_PIXEL, 8'd255);           // second row, first column: no codes yet
    send_word(OP_PIXEL, 8'd0);             // releases (0,0) and (0,1), end of row
    send_word(OP_FLUSH, 8'd0);             // drains (1,0)
    send_word(OP_FLUSH, 8'd255);           // drains (1,1), end of image
    send_word(OP_FLUSH, 8'd0);             // nothing pending
    write_reg(REG_IMAGE_WIDTH, 16'hF803);  // bits above the register dropped: width 3
    send_word(OP_PIXEL, 8'd128);
    send_word(OP_FLUSH, 8'd255);           // mid-image flush: ignored
    repeat (5) send_word(OP_PIXEL, 8'd128); // flat image, all comparisons equal
    send_word(OP_FLUSH, 8'd0);             // start of the drain ...
    send_word(OP_PIXEL, 8'd255);           // ... dropped: this is the new top-left
    send_word(OP_PIXEL, 8'd1);
    send_word(OP_PIXEL, 8'd254);
    send_word(OP_PIXEL, 8'd0);
    send_word(OP_PIXEL, 8'd255);
    send_word(OP_PIXEL, 8'd128);
    repeat (3) send_word(OP_FLUSH, 8'd0);
  endtask

  // Width just above the line store saturates to the maximum, height 0 counts
  // as 2. Only a first-row stretch is sent, so no code may appear.
  task automatic test_full_width();
    write_reg(REG_IMAGE_WIDTH, 16'h0401);
    write_reg(REG_IMAGE_HEIGHT, 16'd0);
    repeat (24) push_word(OP_PIXEL, pix_t'($urandom));
    repeat (2) push_word(OP_FLUSH, pix_t'($urandom));   // mid-image: ignored
  endtask

  // Tallest height (never drained here), then restarts by register writes
  // part way through an image
  task automatic test_restart();
    write_reg(REG_IMAGE_WIDTH, 16'd4);
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    repeat (12) push_word(OP_PIXEL, pix_t'($urandom));
    repeat (2) push_word(OP_FLUSH, pix_t'($urandom));   // still mid-image: ignored
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    repeat (5) push_word(OP_PIXEL, pix_t'($urandom));
    write_reg(REG_IMAGE_WIDTH, 16'd5);
    repeat (15) push_word(OP_PIXEL, pix_t'($urandom));
    repeat (5) push_word(OP_FLUSH, pix_t'($urandom));
  endtask

  // Receiver holds off for a long stretch while a whole image is offered back
  // to back; the result queue fills and the input must stall. Then the sender
  // waits for every code before going on.
  task automatic test_backpressure();
    write_reg(REG_IMAGE_WIDTH, 16'd6);
    write_reg(REG_IMAGE_HEIGHT, 16'd4);
    hold_request = 1'b1;
    repeat (24) send_word(OP_PIXEL, pix_t'($urandom));
    repeat (6) send_word(OP_FLUSH, pix_t'($urandom));
    park_sender();
    wait_results_in();
  endtask

  // Mostly whole images of random small geometry and random content, with
  // loose noise, stray flushes, cut drains and restarts mixed in
  task automatic test_random_images();
    int unsigned start_words, w, h, roll, pick, mode, cut, p, hi_bits;
    pix_t        base;
    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      roll    = $urandom_range(0, 99);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (roll < 12) begin
        // noise: words with no image structure
        repeat ($urandom_range(1, 20))
          push_word(op_t'($urandom_range(0, 1)), pix_t'($urandom));
      end else begin
        if (roll < 55) begin
          pick = $urandom_range(0, 19);
          if (pick < 14)      w = $urandom_range(2, 10);
          else if (pick < 19) w = $urandom_range(11, 40);
          else                w = $urandom_range(41, 130);
          h = (w > 40) ? $urandom_range(2, 3) : $urandom_range(2, 6);
          if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1);
          if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 1);
          hi_bits = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 31) : 0;
          write_reg(REG_IMAGE_WIDTH, CFG_W'(w | (hi_bits << IMG_W_BITS)));
          write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        end
        w    = active_width();
        h    = active_height();
        mode = $urandom_range(0, 3);
        base = pix_t'($urandom);
        if (roll < 18) begin
          // part of an image, then a restart through a register write
          repeat ($urandom_range(1, w * h - 1)) push_word(OP_PIXEL, random_pixel(mode, base));
          write_reg(REG_IMAGE_HEIGHT, height_reg);
        end else begin
          for (p = 0; p < w * h; p++) begin
            if ($urandom_range(0, 39) == 0) push_word(OP_FLUSH, pix_t'($urandom));
            push_word(OP_PIXEL, random_pixel(mode, base));
          end
          pick = $urandom_range(0, 19);
          if (pick < 16)      cut = w;                          // full drain
          else if (pick < 19) cut = $urandom_range(0, w - 1);   // cut short
          else                cut = w + $urandom_range(1, 3);   // extra flushes
          repeat (cut) push_word(OP_FLUSH, pix_t'($urandom));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_IMAGE_WIDTH;
    cfg_wdata          = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.op          = OP_PIXEL;
    pix_ch.pixel_value = '0;
    code_ch.ready      = 1'b0;
    model_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_geometry();
    test_directed_cases();
    test_full_width();
    test_restart();
    test_backpressure();
    test_random_images();

    // everything back, then a quiet tail to catch anything unrequested
    park_sender();
    wait_results_in();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words and %0d results, %0d images drained to the last row",
             words_sent, results_checked, images_drained);
    $display("%0d register writes, %0d cycles of input held off by back-pressure",
             cfg_writes, stall_cycles);
    if (mismatch_count == 0 && expected_codes.size() == 0) begin
      $display("[lbp_3x3_edge_zero_top] OK");
    end else begin
      $display("[lbp_3x3_edge_zero_top] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/lbpz_pkg.sv
hdl/lbpz_if.sv
hdl/lbpz_ram.sv
hdl/lbpz_ctrl.sv
hdl/lbpz_dp.sv
hdl/lbpz_ofifo.sv
hdl/lbp_3x3_edge_zero_top.sv
bench/tb_top.sv
